// ----- design/sem_pkg.sv -----
// shared types and constants for the sobel edge magnitude block
`default_nettype none
package sem_pkg;
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int ADDR_W     = $clog2(MAX_WIDTH);
    localparam int CNT_W      = 11;
    localparam int SAT_LIMIT  = 65025;
    localparam logic REG_FRAME_WIDTH  = 1'b0;
    localparam logic REG_FRAME_HEIGHT = 1'b1;

    typedef struct packed {
        logic       mode;
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
    } t_in_item;

    typedef struct packed {
        logic [7:0] red_edge;
        logic [7:0] green_edge;
        logic [7:0] blue_edge;
        logic       frame_end;
    } t_out_item;

    typedef struct packed {
        logic [23:0]       pix;
        logic [ADDR_W-1:0] addr;
        logic              use_top;
        logic              use_mid;
        logic              col0;
        logic              started;
        logic              last;
    } t_job;
endpackage
`default_nettype wire

// ----- design/sem_ram.sv -----
// generic single write port ram with registered read
`default_nettype none
module sem_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ----- design/sem_front.sv -----
// front end: frame position counters and item classification
`default_nettype none
module sem_front
    import sem_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire t_in_item         i_item,
    input  wire logic [CNT_W-1:0] i_width,
    input  wire logic [CNT_W-1:0] i_height,
    input  wire logic             i_q_full,
    output logic                  o_job_push,
    output t_job                  o_job
);
    logic [CNT_W-1:0] r_ic, r_ir, r_ec, r_er;
    logic [CNT_W-1:0] w, h;
    logic             accept, active, started, col_wrap, last;

    always_comb begin
        if (i_width == '0) w = CNT_W'(1);
        else if (i_width > CNT_W'(MAX_WIDTH)) w = CNT_W'(MAX_WIDTH);
        else w = i_width;
        if (i_height == '0) h = CNT_W'(1);
        else if (i_height > CNT_W'(MAX_HEIGHT)) h = CNT_W'(MAX_HEIGHT);
        else h = i_height;
    end

    assign accept   = i_push && !i_q_full;
    assign active   = r_ir < h;
    assign started  = (r_ir >= CNT_W'(2)) || ((r_ir == CNT_W'(1)) && (r_ic != '0));
    assign col_wrap = ({1'b0, r_ic} + 12'd1) >= {1'b0, w};
    assign last     = (({1'b0, r_er} + 12'd1) >= {1'b0, h})
                   && (({1'b0, r_ec} + 12'd1) >= {1'b0, w});

    assign o_job_push = accept && !(active && i_item.mode);

    always_comb begin
        o_job.pix     = active ? {i_item.red_in, i_item.green_in, i_item.blue_in} : 24'd0;
        o_job.addr    = (r_ic < CNT_W'(MAX_WIDTH)) ? r_ic[ADDR_W-1:0]
                                                   : ADDR_W'(MAX_WIDTH - 1);
        o_job.use_top = r_ir >= CNT_W'(2);
        o_job.use_mid = r_ir >= CNT_W'(1);
        o_job.col0    = r_ic == '0;
        o_job.started = started;
        o_job.last    = started && last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ic <= '0;
            r_ir <= '0;
            r_ec <= '0;
            r_er <= '0;
        end else if (o_job_push) begin
            if (started && last) begin
                r_ic <= '0;
                r_ir <= '0;
                r_ec <= '0;
                r_er <= '0;
            end else begin
                if (col_wrap) begin
                    r_ic <= '0;
                    r_ir <= r_ir + CNT_W'(1);
                end else begin
                    r_ic <= r_ic + CNT_W'(1);
                end
                if (started) begin
                    if (({1'b0, r_ec} + 12'd1) >= {1'b0, w}) begin
                        r_ec <= '0;
                        r_er <= r_er + CNT_W'(1);
                    end else begin
                        r_ec <= r_ec + CNT_W'(1);
                    end
                end
            end
        end
    end
endmodule
`default_nettype wire

// ----- design/sem_jobq.sv -----
// two entry queue between front and back
`default_nettype none
module sem_jobq
    import sem_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_job i_job,
    input  wire logic i_pop,
    output logic      o_full,
    output logic      o_empty,
    output t_job      o_job
);
    t_job       r_q [2];
    logic       r_rd, r_wr;
    logic [1:0] r_cnt;

    assign o_full  = r_cnt == 2'd2;
    assign o_empty = r_cnt == 2'd0;
    assign o_job   = r_q[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wr] <= i_job;
        end
        if (!i_rst_n) begin
            r_rd  <= 1'b0;
            r_wr  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wr <= !r_wr;
            if (i_pop) r_rd <= !r_rd;
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end
endmodule
`default_nettype wire

// ----- design/sem_back.sv -----
// back end: line stores, window, sobel magnitude and result queue
`default_nettype none
module sem_back
    import sem_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_job_empty,
    input  wire t_job i_job,
    output logic      o_job_pop,
    input  wire logic i_pop,
    output logic      o_empty,
    output t_out_item o_result
);
    typedef enum logic [2:0] {S_IDLE, S_READ, S_WIN, S_MUL, S_SUM, S_ROOT, S_RND} t_state;

    t_state      r_state;
    t_job        r_job;
    logic [23:0] r_win  [3][3];
    logic [23:0] r_calc [3][3];
    logic [19:0] r_sqx [3];
    logic [19:0] r_sqy [3];
    logic [20:0] r_s [3];
    logic [8:0]  r_n [3];
    logic [3:0]  r_bit;
    t_out_item   r_oq [2];
    logic        r_ord, r_owr;
    logic [1:0]  r_ocnt;

    logic [23:0] up_q, mid_q, top, mid;
    logic [23:0] n_win  [3][3];
    logic [23:0] n_calc [3][3];
    logic signed [11:0] gx [3];
    logic signed [11:0] gy [3];
    logic [8:0]  t [3];
    logic [7:0]  fin [3];
    logic        we;
    t_out_item   res;

    assign o_job_pop = (r_state == S_IDLE) && !i_job_empty && (r_ocnt != 2'd2);
    assign we        = r_state == S_WIN;
    assign top       = r_job.use_top ? up_q : 24'd0;
    assign mid       = r_job.use_mid ? mid_q : 24'd0;

    sem_ram #(.WIDTH(24), .DEPTH(MAX_WIDTH)) u_upper (
        .i_clk(i_clk), .i_we(we), .i_waddr(r_job.addr), .i_wdata(mid),
        .i_raddr(r_job.addr), .o_rdata(up_q)
    );
    sem_ram #(.WIDTH(24), .DEPTH(MAX_WIDTH)) u_middle (
        .i_clk(i_clk), .i_we(we), .i_waddr(r_job.addr), .i_wdata(r_job.pix),
        .i_raddr(r_job.addr), .o_rdata(mid_q)
    );

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            if (r_job.col0) begin
                n_calc[r][0] = r_win[r][1];
                n_calc[r][1] = r_win[r][2];
                n_calc[r][2] = 24'd0;
                n_win[r][0]  = 24'd0;
                n_win[r][1]  = 24'd0;
            end else begin
                n_win[r][0]  = r_win[r][1];
                n_win[r][1]  = r_win[r][2];
                n_calc[r][0] = r_win[r][1];
                n_calc[r][1] = r_win[r][2];
                n_calc[r][2] = 24'd0;
            end
        end
        n_win[0][2] = top;
        n_win[1][2] = mid;
        n_win[2][2] = r_job.pix;
        if (!r_job.col0) begin
            n_calc[0][2] = top;
            n_calc[1][2] = mid;
            n_calc[2][2] = r_job.pix;
        end
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            gx[k] = (12'(r_calc[0][2][23-8*k -: 8]) + (12'(r_calc[1][2][23-8*k -: 8]) << 1)
                   + 12'(r_calc[2][2][23-8*k -: 8]))
                  - (12'(r_calc[0][0][23-8*k -: 8]) + (12'(r_calc[1][0][23-8*k -: 8]) << 1)
                   + 12'(r_calc[2][0][23-8*k -: 8]));
            gy[k] = (12'(r_calc[2][0][23-8*k -: 8]) + (12'(r_calc[2][1][23-8*k -: 8]) << 1)
                   + 12'(r_calc[2][2][23-8*k -: 8]))
                  - (12'(r_calc[0][0][23-8*k -: 8]) + (12'(r_calc[0][1][23-8*k -: 8]) << 1)
                   + 12'(r_calc[0][2][23-8*k -: 8]));
            t[k] = r_n[k] | (9'd1 << r_bit);
            if (r_s[k] > 21'(SAT_LIMIT)) fin[k] = 8'd255;
            else if (r_s[k] > 21'({9'd0, r_n[k]} * {9'd0, r_n[k]} + {9'd0, r_n[k]}))
                fin[k] = r_n[k][7:0] + 8'd1;
            else fin[k] = r_n[k][7:0];
        end
        res.red_edge   = fin[0];
        res.green_edge = fin[1];
        res.blue_edge  = fin[2];
        res.frame_end  = r_job.last;
    end

    assign o_empty  = r_ocnt == 2'd0;
    assign o_result = r_oq[r_ord];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ord   <= 1'b0;
            r_owr   <= 1'b0;
            r_ocnt  <= '0;
            r_bit   <= '0;
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    r_win[r][c] <= 24'd0;
                end
            end
        end else begin
            if (i_pop && !o_empty) r_ord <= !r_ord;
            r_ocnt <= r_ocnt + 2'(r_state == S_RND) - 2'(i_pop && !o_empty);
            unique case (r_state)
                S_IDLE: begin
                    if (o_job_pop) begin
                        r_job   <= i_job;
                        r_state <= S_READ;
                    end
                end
                S_READ: r_state <= S_WIN;
                S_WIN: begin
                    r_win   <= n_win;
                    r_calc  <= n_calc;
                    r_state <= r_job.started ? S_MUL : S_IDLE;
                end
                S_MUL: begin
                    for (int k = 0; k < 3; k++) begin
                        r_sqx[k] <= 20'(gx[k] * gx[k]);
                        r_sqy[k] <= 20'(gy[k] * gy[k]);
                    end
                    r_state <= S_SUM;
                end
                S_SUM: begin
                    for (int k = 0; k < 3; k++) begin
                        r_s[k] <= {1'b0, r_sqx[k]} + {1'b0, r_sqy[k]};
                        r_n[k] <= '0;
                    end
                    r_bit   <= 4'd8;
                    r_state <= S_ROOT;
                end
                S_ROOT: begin
                    for (int k = 0; k < 3; k++) begin
                        if (21'({9'd0, t[k]} * {9'd0, t[k]}) <= r_s[k]) r_n[k] <= t[k];
                    end
                    r_bit <= r_bit - 4'd1;
                    if (r_bit == '0) r_state <= S_RND;
                end
                S_RND: begin
                    r_oq[r_owr] <= res;
                    r_owr       <= !r_owr;
                    r_state     <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// ----- design/sobel_edge_magnitude_rgb.sv -----
// top level: sobel edge magnitude on rgb pixels with apb configuration
// the shared back end takes a new item only when idle and the result queue has room;
//   it steps through memory read, window, multiply, sum, 9 root steps and rounding,
//   and a warm-up item goes back to idle after the window step
// reset: counters and window clear, frame size 640 x 480; line memories are not cleared
`default_nettype none
module sobel_edge_magnitude_rgb
    import sem_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire t_in_item    i_item,
    output logic             empty,
    input  wire logic        pop,
    output t_out_item        o_result,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    logic [CNT_W-1:0] r_width, r_height;
    logic             job_push, job_pop, job_empty;
    t_job             job_in, job_out;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_FRAME_HEIGHT) ? {21'd0, r_height} : {21'd0, r_width};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= CNT_W'(640);
            r_height <= CNT_W'(480);
        end else if (psel && penable && pwrite && pready) begin
            if (paddr[2] == REG_FRAME_WIDTH) r_width <= pwdata[CNT_W-1:0];
            else r_height <= pwdata[CNT_W-1:0];
        end
    end

    sem_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(push), .i_item(i_item),
        .i_width(r_width), .i_height(r_height), .i_q_full(full),
        .o_job_push(job_push), .o_job(job_in)
    );

    sem_jobq u_jobq (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(job_push), .i_job(job_in),
        .i_pop(job_pop), .o_full(full), .o_empty(job_empty), .o_job(job_out)
    );

    sem_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_job_empty(job_empty), .i_job(job_out),
        .o_job_pop(job_pop), .i_pop(pop), .o_empty(empty), .o_result(o_result)
    );
endmodule
`default_nettype wire
